/* sv/hpt_pkg.sv */
// Shared constants and types for the homogeneous point transform.
package hpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_REGS  = 8;
    localparam int NUM_ELEMS = 16;
    localparam int NUM_LANES = 3;
    localparam int NUM_ROWS  = 4;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int Q_W       = DATA_W + 2;
    localparam int REM_W     = SUM_W + FRAC_BITS;
    localparam int DSH_W     = SUM_W + Q_W - 1;

    localparam logic [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [NUM_LANES-1:0][REM_W-1:0] rem;
        logic [NUM_LANES-1:0][Q_W-1:0]   quo;
        logic [DSH_W-1:0]                dsh;
        logic [NUM_LANES-1:0]            neg;
        logic                            zero_w;
    } t_div;

endpackage

/* sv/homogeneous_point_transform.sv */
// Pipeline: multiply, sum, divide setup, 34 divide steps, output register.
// Throughput: one beat per cycle unless i_ready stalls the output; the rate
// is set by the 34-stage pipelined restoring divider, one quotient bit per
// stage for all three lanes.
// Reset: synchronous active low; clears valid bits and loads the identity.
module homogeneous_point_transform (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic signed [hpt_pkg::DATA_W-1:0] i_vec_x,
    input  logic signed [hpt_pkg::DATA_W-1:0] i_vec_y,
    input  logic signed [hpt_pkg::DATA_W-1:0] i_vec_z,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [hpt_pkg::DATA_W-1:0] o_out_x,
    output logic signed [hpt_pkg::DATA_W-1:0] o_out_y,
    output logic signed [hpt_pkg::DATA_W-1:0] o_out_z,
    output logic                            o_zero_w,
    output logic                            o_saturated,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hpt_pkg::CFG_W-1:0]       i_cfg_data
);
    import hpt_pkg::*;

    logic [CFG_W-1:0] r_mat [NUM_REGS];
    logic signed [DATA_W-1:0] w_e [NUM_ELEMS];
    logic signed [DATA_W-1:0] w_v [NUM_LANES];

    logic                     r_a_v;
    logic signed [PROD_W-1:0] r_a_prod [NUM_ROWS][NUM_LANES];
    logic signed [SUM_W-1:0]  r_a_ext [NUM_ROWS];
    logic                     r_b_v;
    logic signed [SUM_W-1:0]  r_b_sum [NUM_ROWS];
    logic                     r_c_v;
    t_div                     r_c;
    logic                     r_d_v [Q_W];
    t_div                     r_d [Q_W];
    t_div                     w_step [Q_W];
    logic                     r_e_v;

    logic adv_a, adv_b, adv_c, adv_e;
    logic adv_d [Q_W];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_mat[k] <= '0;
            r_mat[0] <= CFG_W'(ONE);
            r_mat[2] <= {ONE, {DATA_W{1'b0}}};
            r_mat[5] <= CFG_W'(ONE);
            r_mat[7] <= {ONE, {DATA_W{1'b0}}};
        end else if (i_cfg_valid && i_cfg_index < CFG_IDX_W'(NUM_REGS)) begin
            r_mat[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    for (genvar g = 0; g < NUM_ELEMS; g++) begin : g_elem
        assign w_e[g] = r_mat[g/2][(g%2)*DATA_W +: DATA_W];
    end

    assign w_v[0] = i_vec_x;
    assign w_v[1] = i_vec_y;
    assign w_v[2] = i_vec_z;

    // ready chain, back to front
    always_comb begin
        adv_e = !r_e_v || i_ready;
        adv_d[Q_W-1] = !r_d_v[Q_W-1] || adv_e;
        for (int k = Q_W-2; k >= 0; k--) adv_d[k] = !r_d_v[k] || adv_d[k+1];
        adv_c = !r_c_v || adv_d[0];
        adv_b = !r_b_v || adv_c;
        adv_a = !r_a_v || adv_b;
    end
    assign o_ready = adv_a;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (adv_a) r_a_v <= i_valid;
        if (adv_a && i_valid) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < NUM_LANES; c++) begin
                    r_a_prod[r][c] <= w_e[r*4+c] * w_v[c];
                end
                if (!i_func) r_a_ext[r] <= SUM_W'(w_e[r*4+3]) <<< FRAC_BITS;
                else if (r == NUM_ROWS-1) r_a_ext[r] <= SUM_W'(1) << (2*FRAC_BITS);
                else r_a_ext[r] <= '0;
            end
        end
    end

    // sum stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else if (adv_b) r_b_v <= r_a_v;
        if (adv_b && r_a_v) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_b_sum[r] <= r_a_ext[r] + SUM_W'(r_a_prod[r][0])
                            + SUM_W'(r_a_prod[r][1]) + SUM_W'(r_a_prod[r][2]);
            end
        end
    end

    // divide setup: magnitudes and signs
    always_ff @(posedge i_clk) begin
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] wmag;
        if (!i_rst_n) r_c_v <= 1'b0;
        else if (adv_c) r_c_v <= r_b_v;
        if (adv_c && r_b_v) begin
            wmag = r_b_sum[NUM_ROWS-1][SUM_W-1] ? -r_b_sum[NUM_ROWS-1]
                                                : r_b_sum[NUM_ROWS-1];
            for (int l = 0; l < NUM_LANES; l++) begin
                mag = r_b_sum[l][SUM_W-1] ? -r_b_sum[l] : r_b_sum[l];
                r_c.rem[l] <= REM_W'(mag) << FRAC_BITS;
                r_c.quo[l] <= '0;
                r_c.neg[l] <= r_b_sum[l][SUM_W-1] ^ r_b_sum[NUM_ROWS-1][SUM_W-1];
            end
            r_c.dsh    <= DSH_W'(wmag) << (Q_W-1);
            r_c.zero_w <= (r_b_sum[NUM_ROWS-1] == '0);
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        if (k == 0) begin : g_first
            hpt_div_step u_step (.i_stage(r_c), .o_stage(w_step[k]));
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_d_v[k] <= 1'b0;
                else if (adv_d[k]) r_d_v[k] <= r_c_v;
                if (adv_d[k] && r_c_v) r_d[k] <= w_step[k];
            end
        end else begin : g_rest
            hpt_div_step u_step (.i_stage(r_d[k-1]), .o_stage(w_step[k]));
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_d_v[k] <= 1'b0;
                else if (adv_d[k]) r_d_v[k] <= r_d_v[k-1];
                if (adv_d[k] && r_d_v[k-1]) r_d[k] <= w_step[k];
            end
        end
    end

    // sign, clamp and output register
    always_ff @(posedge i_clk) begin
        logic [Q_W-1:0]    q;
        logic              s;
        logic              any;
        logic [DATA_W-1:0] val [NUM_LANES];
        if (!i_rst_n) r_e_v <= 1'b0;
        else if (adv_e) r_e_v <= r_d_v[Q_W-1];
        if (adv_e && r_d_v[Q_W-1]) begin
            any = 1'b0;
            for (int l = 0; l < NUM_LANES; l++) begin
                q = r_d[Q_W-1].quo[l];
                if (r_d[Q_W-1].neg[l]) begin
                    s = q[Q_W-1] | q[Q_W-2] | (q[DATA_W-1] & |q[DATA_W-2:0]);
                    val[l] = s ? NEG_MAX : -q[DATA_W-1:0];
                end else begin
                    s = |q[Q_W-1:DATA_W-1];
                    val[l] = s ? POS_MAX : q[DATA_W-1:0];
                end
                any = any | s;
            end
            if (r_d[Q_W-1].zero_w) begin
                o_out_x     <= '0;
                o_out_y     <= '0;
                o_out_z     <= '0;
                o_zero_w    <= 1'b1;
                o_saturated <= 1'b0;
            end else begin
                o_out_x     <= val[0];
                o_out_y     <= val[1];
                o_out_z     <= val[2];
                o_zero_w    <= 1'b0;
                o_saturated <= any;
            end
        end
    end
    assign o_valid = r_e_v;

endmodule

/* sv/hpt_div_step.sv */
// One restoring division step shared by the three lanes.
module hpt_div_step (
    input  hpt_pkg::t_div i_stage,
    output hpt_pkg::t_div o_stage
);
    import hpt_pkg::*;

    always_comb begin
        o_stage     = i_stage;
        o_stage.dsh = i_stage.dsh >> 1;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (DSH_W'(i_stage.rem[l]) >= i_stage.dsh) begin
                o_stage.rem[l] = i_stage.rem[l] - REM_W'(i_stage.dsh);
                o_stage.quo[l] = {i_stage.quo[l][Q_W-2:0], 1'b1};
            end else begin
                o_stage.quo[l] = {i_stage.quo[l][Q_W-2:0], 1'b0};
            end
        end
    end

endmodule

/* sv/hpt_checker.sv */
// Port-level checks for the homogeneous point transform, with bind.
module hpt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [hpt_pkg::DATA_W-1:0]    o_out_x,
    input logic [hpt_pkg::DATA_W-1:0]    o_out_y,
    input logic [hpt_pkg::DATA_W-1:0]    o_out_z,
    input logic                          o_zero_w,
    input logic                          o_saturated
);
    import hpt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
            && $stable(o_out_z) && $stable(o_saturated))
        else $error("result beat changed while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_w |-> o_out_x == '0 && o_out_y == '0 && o_out_z == '0
            && !o_saturated)
        else $error("zero w beat not cleared");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_out_x == POS_MAX || o_out_x == NEG_MAX
            || o_out_y == POS_MAX || o_out_y == NEG_MAX
            || o_out_z == POS_MAX || o_out_z == NEG_MAX)
        else $error("saturated flag without clamped component");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
    .o_zero_w(o_zero_w), .o_saturated(o_saturated)
);

/* tb/sv/tb_top.sv */
// Self-checking regression for the homogeneous point transform block.
`timescale 1ns / 100ps

module tb_top;
    import hpt_pkg::*;

    localparam int LATENCY      = 38;
    localparam int WATCHDOG_MAX = 20000;
    localparam int N_RANDOM     = 650;

    localparam logic FUNC_POINT  = 1'b0;
    localparam logic FUNC_VECTOR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_E0_E1   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_E14_E15 = 4'd7;
    localparam logic [CFG_IDX_W-1:0] REG_BAD     = 4'd12;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic              zero_w;
        logic              saturated;
    } t_xform;

    typedef struct {
        logic              func;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic              typed;
        t_xform            res;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_func = 1'b0;
    logic [DATA_W-1:0] i_vec_x = '0;
    logic [DATA_W-1:0] i_vec_y = '0;
    logic [DATA_W-1:0] i_vec_z = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [DATA_W-1:0] o_out_x;
    logic [DATA_W-1:0] o_out_y;
    logic [DATA_W-1:0] o_out_z;
    logic              o_zero_w;
    logic              o_saturated;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    logic [CFG_W-1:0] matrix_regs [NUM_REGS];
    t_xform           pending_xforms [$];
    int               n_errors = 0;
    int               idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    homogeneous_point_transform u_dut (.*);

    function automatic logic signed [DATA_W-1:0] elem(int i);
        return matrix_regs[i / 2][(i % 2) * 32 +: 32];
    endfunction

    function automatic logic signed [DATA_W-1:0] div_sat(
        logic signed [127:0] num, logic signed [127:0] den, ref logic sat);
        logic signed [127:0] q;
        q = (num <<< FRAC_BITS) / den;
        if (q > 128'sd2147483647) begin
            sat = 1'b1;
            return POS_MAX;
        end
        if (q < -128'sd2147483648) begin
            sat = 1'b1;
            return NEG_MAX;
        end
        return q[DATA_W-1:0];
    endfunction

    function automatic t_xform transform(logic func, logic [DATA_W-1:0] x,
                                         logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
        logic signed [127:0] v [3];
        logic signed [127:0] acc [4];
        logic                sat;
        t_xform              r;
        v[0] = $signed(x);
        v[1] = $signed(y);
        v[2] = $signed(z);
        sat  = 1'b0;
        for (int row = 0; row < 4; row++) begin
            if (func == FUNC_POINT)
                acc[row] = 128'(elem(row * 4 + 3)) <<< FRAC_BITS;
            else if (row == 3)
                acc[row] = 128'sd1 <<< (2 * FRAC_BITS);
            else
                acc[row] = '0;
            for (int c = 0; c < 3; c++)
                acc[row] += 128'(elem(row * 4 + c)) * v[c];
        end
        r = '0;
        if (acc[3] == 0) begin
            r.zero_w = 1'b1;
            return r;
        end
        r.x = div_sat(acc[0], acc[3], sat);
        r.y = div_sat(acc[1], acc[3], sat);
        r.z = div_sat(acc[2], acc[3], sat);
        r.saturated = sat;
        return r;
    endfunction

    task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // result side: random stall, compare against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_xforms.size() == 0) begin
                report("unexpected beat", o_out_x, '0);
            end else begin
                t_xform e;
                e = pending_xforms.pop_front();
                if (o_out_x !== e.x) report("out_x", o_out_x, e.x);
                if (o_out_y !== e.y) report("out_y", o_out_y, e.y);
                if (o_out_z !== e.z) report("out_z", o_out_z, e.z);
                if (o_zero_w !== e.zero_w)
                    report("zero_w", DATA_W'(o_zero_w), DATA_W'(e.zero_w));
                if (o_saturated !== e.saturated)
                    report("saturated", DATA_W'(o_saturated), DATA_W'(e.saturated));
            end
        end
        if ($urandom_range(0, 99) < 70) i_ready <= 1'b1;
        else if ($urandom_range(0, 9) == 0) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("homogeneous_point_transform regression: fail");
            $finish;
        end
    end

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) n = 0;
        else if (n < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 40);
        if (n > 0) i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(logic func, logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                             logic [DATA_W-1:0] z, logic typed, t_xform res);
        t_xform e;
        e = transform(func, x, y, z);
        if (typed && e !== res) begin
            $display("directed row disagrees with prediction");
            n_errors++;
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_xforms.push_back(e);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_xforms.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx < NUM_REGS) matrix_regs[idx[2:0]] = data;
        @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ONE;
            2: return $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
            3: return $urandom;
            default: return DATA_W'($signed($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
            2: return '0;
            default: return DATA_W'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    task automatic random_matrix(int kind);
        logic [DATA_W-1:0] e [NUM_ELEMS];
        for (int i = 0; i < NUM_ELEMS; i++) begin
            if (kind == 0) e[i] = (i % 5 == 0) ? ONE : '0;
            else if (kind == 1) e[i] = (i % 2) ? POS_MAX : NEG_MAX;
            else e[i] = rand_elem();
        end
        // keep w well away from zero most of the time, except for the zero-w phase
        if (kind == 3) begin
            e[12] = '0; e[13] = '0; e[14] = '0; e[15] = '0;
        end else if (kind == 2 && $urandom_range(0, 2) != 0) begin
            e[12] = '0; e[13] = '0; e[14] = DATA_W'($urandom_range(0, 255));
            e[15] = ONE;
        end
        for (int k = 0; k < NUM_REGS; k++)
            write_reg(k[CFG_IDX_W-1:0], {e[2 * k + 1], e[2 * k]});
    endtask

    t_row directed [] = '{
        '{FUNC_POINT,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
        '{FUNC_POINT,  32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 1'b1,
          '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 1'b0, 1'b0}},
        '{FUNC_VECTOR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0}},
        '{FUNC_POINT,  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{FUNC_VECTOR, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b1,
          '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0}},
        '{FUNC_POINT,  32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_0F0F, 1'b0, '0}
    };

    initial begin
        for (int k = 0; k < NUM_REGS; k++) matrix_regs[k] = '0;
        matrix_regs[0] = CFG_W'(ONE);
        matrix_regs[2] = CFG_W'(ONE) << 32;
        matrix_regs[5] = CFG_W'(ONE);
        matrix_regs[7] = CFG_W'(ONE) << 32;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_item(directed[i].func, directed[i].x, directed[i].y, directed[i].z,
                      directed[i].typed, directed[i].res);
        drain();

        // scaled perspective, zero w, saturation, stray index
        write_reg(REG_E14_E15, {32'h0000_0000, 32'h0001_0000});
        write_reg(REG_BAD, {CFG_W{1'b1}});
        send_item(FUNC_POINT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
                  '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0});
        send_item(FUNC_POINT, 32'h0001_0000, 32'h0001_0000, 32'h0000_0001, 1'b0, '0);
        send_item(FUNC_VECTOR, 32'h0003_0000, 32'hFFFD_0000, 32'hFFFF_0000, 1'b1,
                  '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0});
        send_item(FUNC_VECTOR, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
        drain();
        write_reg(REG_E0_E1, {32'h0000_0000, POS_MAX});
        send_item(FUNC_POINT, POS_MAX, 32'h0, 32'h0001_0000, 1'b0, '0);
        send_item(FUNC_POINT, NEG_MAX, 32'h0, 32'h0001_0000, 1'b0, '0);
        send_item(FUNC_VECTOR, 32'h0000_0001, 32'h0, 32'h0000_0000, 1'b0, '0);
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            random_matrix(phase == 0 ? 0 : phase == 1 ? 1 : phase == 5 ? 3 : 2);
            for (int n = 0; n < N_RANDOM / 10; n++) begin
                send_item(1'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(),
                          1'b0, '0);
                if (n == 30) begin
                    i_valid <= 1'b0;
                    while (pending_xforms.size() != 0) @(posedge i_clk);
                end else if ($urandom_range(0, 4) != 0) idle_gap();
            end
            drain();
        end

        if (n_errors == 0)
            $display("homogeneous_point_transform regression: pass");
        else
            $display("homogeneous_point_transform regression: fail");
        $finish;
    end
endmodule
